/* design/bdqks_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdqks_pkg: shared types and constants of the bounded deque
// Request and status codes, store geometry and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bdqks_pkg;

	// store geometry
	localparam int LIST_DEPTH = 32;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int KEY_W      = 32;
	localparam int FOUND_W    = 5;

	// request codes
	typedef enum logic [1:0] {
		REQ_PUSH     = 2'd0,
		REQ_POP_HEAD = 2'd1,
		REQ_POP_TAIL = 2'd2,
		REQ_SEARCH   = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    latch_req;
		logic    write_tail;
		logic    read_head;
		logic    read_tail;
		logic    search_first;
		logic    search_next;
		logic    res_status_en;
		status_t res_status;
		logic    res_found_en;
		logic    res_removed_en;
		logic    load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req_type;
		logic empty;
		logic full;
		logic match;
		logic last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

/* design/bdqks_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdqks_if: request and response channels of the bounded deque
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface bdqks_req_if;
	import bdqks_pkg::*;

	logic                    valid;
	logic                    ready;
	req_t                    req_type;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output req_type, output key, input ready);
	modport sink (input valid, input req_type, input key, output ready);
endinterface

interface bdqks_rsp_if;
	import bdqks_pkg::*;

	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic [FOUND_W-1:0]      found_index;
	logic signed [KEY_W-1:0] removed_key;

	modport source (output valid, output status, output found_index,
		output removed_key, input ready);
	modport sink (input valid, input status, input found_index,
		input removed_key, output ready);
endinterface
`default_nettype wire

/* design/bdqks_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdqks_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdqks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/bdqks_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdqks_ctrl: request sequencer of the bounded deque
// Accepts one request, steps the datapath through it and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module bdqks_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bdqks_pkg::dp_sts_t sts,
	output bdqks_pkg::dp_cmd_t      cmd
);
	import bdqks_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SRCH = 5'b00100,
		S_POP  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// decode state and status into commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.res_status_en = 1'b1;
				cmd.res_status    = ST_OK;
				state_d           = S_FIN;
				unique case (sts.req_type)
					REQ_PUSH: begin
						if (sts.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.write_tail = 1'b1;
						end
					end
					REQ_POP_HEAD: begin
						if (sts.empty) begin
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.read_head = 1'b1;
							state_d       = S_POP;
						end
					end
					REQ_POP_TAIL: begin
						if (sts.empty) begin
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.read_tail = 1'b1;
							state_d       = S_POP;
						end
					end
					REQ_SEARCH: begin
						cmd.res_status = ST_NOT_FOUND;
						if (!sts.empty) begin
							cmd.search_first = 1'b1;
							state_d          = S_SRCH;
						end
					end
				endcase
			end
			S_SRCH: begin
				// compare one entry a cycle, fetching the next meanwhile
				if (sts.match) begin
					cmd.res_status_en = 1'b1;
					cmd.res_status    = ST_OK;
					cmd.res_found_en  = 1'b1;
					state_d           = S_FIN;
				end else if (sts.last) begin
					state_d = S_FIN;
				end else begin
					cmd.search_next = 1'b1;
				end
			end
			S_POP: begin
				cmd.res_removed_en = 1'b1;
				state_d            = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/bdqks_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdqks_dp: datapath of the bounded deque
// Head and count registers, circular slot arithmetic, the entry RAM,
// the search pointer and the result and output registers.
// ----------------------------------------------------------------------------
module bdqks_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bdqks_pkg::req_t               in_req_type,
	input  wire logic signed [bdqks_pkg::KEY_W-1:0] in_key,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output bdqks_pkg::status_t                 out_status,
	output logic [bdqks_pkg::FOUND_W-1:0]      out_found_index,
	output logic signed [bdqks_pkg::KEY_W-1:0] out_removed_key,
	input  wire bdqks_pkg::dp_cmd_t            cmd,
	output bdqks_pkg::dp_sts_t                 sts
);
	import bdqks_pkg::*;

	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   ptr_q;
	req_t               req_type_q;
	logic [KEY_W-1:0]   key_q;
	status_t            res_status_q;
	logic [FOUND_W-1:0] res_found_q;
	logic [KEY_W-1:0]   res_removed_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [FOUND_W-1:0] out_found_q;
	logic [KEY_W-1:0]   out_removed_q;

	logic [CNT_W-1:0]   ptr_next;
	logic [CNT_W-1:0]   tail_off;
	logic [IDX_W-1:0]   waddr;
	logic [IDX_W-1:0]   raddr;
	logic               ram_re;
	logic [KEY_W-1:0]   ram_rdata;

	// wrap head plus offset into the circular store
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(LIST_DEPTH)) begin
			sum = sum - (CNT_W+1)'(LIST_DEPTH);
		end
		return IDX_W'(sum);
	endfunction

	assign ptr_next = CNT_W'(ptr_q) + CNT_W'(1);
	assign tail_off = count_q - CNT_W'(1);
	assign waddr    = slot_of(head_q, count_q);
	assign ram_re   = cmd.read_head | cmd.read_tail | cmd.search_first | cmd.search_next;

	// select the read slot
	always_comb begin
		raddr = slot_of(head_q, '0);
		if (cmd.read_tail) begin
			raddr = slot_of(head_q, tail_off);
		end else if (cmd.search_next) begin
			raddr = slot_of(head_q, ptr_next);
		end
	end

	bdqks_ram #(
		.WIDTH(KEY_W),
		.DEPTH(LIST_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write_tail),
		.waddr (waddr),
		.wdata (key_q),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// advance head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.write_tail) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.read_head) begin
				head_q  <= slot_of(head_q, CNT_W'(1));
				count_q <= tail_off;
			end else if (cmd.read_tail) begin
				count_q <= tail_off;
			end
		end
	end

	// request, search pointer and result registers
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_type_q    <= in_req_type;
			key_q         <= in_key;
			res_found_q   <= '0;
			res_removed_q <= '0;
		end
		if (cmd.search_first) begin
			ptr_q <= '0;
		end else if (cmd.search_next) begin
			ptr_q <= IDX_W'(ptr_next);
		end
		if (cmd.res_status_en) begin
			res_status_q <= cmd.res_status;
		end
		if (cmd.res_found_en) begin
			res_found_q <= FOUND_W'(ptr_q);
		end
		if (cmd.res_removed_en) begin
			res_removed_q <= ram_rdata;
		end
		if (cmd.load_out) begin
			out_status_q  <= res_status_q;
			out_found_q   <= res_found_q;
			out_removed_q <= res_removed_q;
		end
	end

	// output register valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_found_index = out_found_q;
	assign out_removed_key = $signed(out_removed_q);

	// status towards the controller
	assign sts.req_type = req_type_q;
	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CNT_W'(LIST_DEPTH));
	assign sts.match    = (ram_rdata == key_q);
	assign sts.last     = (ptr_next == count_q);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

/* design/bounded_deque_with_key_search.sv */
`default_nettype none
// A push or a rejected request passes through S_EXEC and S_FIN, a pop through
// S_EXEC, S_POP and S_FIN, and a search through S_EXEC, S_SRCH and S_FIN.
// A search compares n entries in S_SRCH, one entry compared a cycle; n is at most
// LIST_DEPTH, and the single read port of the entry RAM sets that rate.
// A pending result sits in the output register while the next request is taken.
// Reset (arst_n low) empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// bounded_deque_with_key_search: bounded deque with linear key search
// Push at tail, pop head, pop tail and first-match search over a circular
// store, with one response transaction for every request transaction.
// ----------------------------------------------------------------------------
module bounded_deque_with_key_search (
	input wire logic  clk,
	input wire logic  arst_n,
	bdqks_req_if.sink req,
	bdqks_rsp_if.source rsp
);
	import bdqks_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bdqks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdqks_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_req_type     (req.req_type),
		.in_key          (req.key),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_found_index (rsp.found_index),
		.out_removed_key (rsp.removed_key),
		.cmd             (cmd),
		.sts             (sts)
	);

`ifndef NO_ASSERTIONS
	// a request is latched exactly when a transaction is accepted
	a_latch_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_req == (req.valid && req.ready))
		else $error("request latch does not match accepted transaction");

	// at most one store access command at a time
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.write_tail, cmd.read_head, cmd.read_tail,
			cmd.search_first, cmd.search_next}))
		else $error("conflicting store access commands");

	// never overwrite a result that has not been taken
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("output register loaded while occupied");

	// a loaded result appears on the response channel
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp.valid)
		else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

/* bench/bdqks_checker.sv */
// ----------------------------------------------------------------------------
// deque_checker: scoreboard for the bounded deque
// Watches the request and response channels and keeps a shadow copy of the
// list. It works out the expected result of every request transaction and
// compares each response transaction, field by field, with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module deque_checker (
	input  logic        clk,
	input  logic        arst_n,
	bdqks_req_if        req,
	bdqks_rsp_if        rsp,
	output int unsigned pending,
	output int unsigned errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import bdqks_pkg::*;

	typedef struct packed {
		status_t                 status;
		logic [FOUND_W-1:0]      found_index;
		logic signed [KEY_W-1:0] removed_key;
	} deque_result_t;

	// shadow list: circular store, head slot and number of keys held
	logic signed [KEY_W-1:0] shadow_keys [LIST_DEPTH];
	logic [IDX_W-1:0]        shadow_head;
	logic [CNT_W-1:0]        shadow_count;
	deque_result_t           due_results [$];

	initial errors = 0;

	task automatic note_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// slot that lies a given distance from the head
	function automatic logic [IDX_W-1:0] slot_at(input int offset);
		return IDX_W'((int'(shadow_head) + offset) % LIST_DEPTH);
	endfunction

	// apply one request to the shadow list and give its result
	task automatic deque_apply(input req_t op, input logic signed [KEY_W-1:0] k,
			output deque_result_t r);
		bit hit;
		hit = 1'b0;
		r.status      = ST_OK;
		r.found_index = '0;
		r.removed_key = '0;
		case (op)
			REQ_PUSH: begin
				if (int'(shadow_count) >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_keys[slot_at(int'(shadow_count))] = k;
					shadow_count++;
				end
			end
			REQ_POP_HEAD: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed_key = shadow_keys[slot_at(0)];
					shadow_head   = slot_at(1);
					shadow_count--;
				end
			end
			REQ_POP_TAIL: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed_key = shadow_keys[slot_at(int'(shadow_count) - 1)];
					shadow_count--;
				end
			end
			default: begin
				// first match from the head wins
				r.status = ST_NOT_FOUND;
				for (int i = 0; i < int'(shadow_count); i++) begin
					if (!hit && shadow_keys[slot_at(i)] == k) begin
						hit           = 1'b1;
						r.status      = ST_OK;
						r.found_index = FOUND_W'(i);
					end
				end
			end
		endcase
	endtask

	// retire responses before taking new requests in the same cycle
	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			shadow_head  = '0;
			shadow_count = '0;
			due_results.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					note_mismatch($sformatf("response with nothing outstanding, status %0d",
						rsp.status));
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status)
						note_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
					if (rsp.found_index !== want.found_index)
						note_mismatch($sformatf("found_index %0d, expected %0d",
							rsp.found_index, want.found_index));
					if (rsp.removed_key !== want.removed_key)
						note_mismatch($sformatf("removed_key %0d, expected %0d",
							rsp.removed_key, want.removed_key));
				end
			end
			if (req.valid && req.ready) begin
				deque_apply(req.req_type, req.key, want);
				due_results.push_back(want);
			end
		end
		pending = due_results.size();
	end

endmodule

/* bench/tb_bounded_deque_with_key_search.sv */
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_key_search: testbench of the bounded deque
// Drives a directed run over empty, duplicate and extreme keys, then random
// traffic in blocks that grow, drain or mix the list, with random gaps on
// both channels and long response hold-offs. The checker scores the results.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_key_search;
	timeunit 1ns;
	timeprecision 1ps;
	import bdqks_pkg::*;

	localparam int RANDOM_ITEMS   = 1530;
	localparam int BLOCK_ITEMS    = 40;
	localparam int IDLE_PERCENT   = 11;
	localparam int QUIET_FIRST    = 400;
	localparam int QUIET_LAST     = 699;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RECENT_KEYS    = 48;

	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef enum {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} traffic_bias_t;

	logic                    clk;
	logic                    arst_n;
	int unsigned             pending;
	int unsigned             errors;
	int unsigned             offered = 0;
	int unsigned             stalled_cycles = 0;
	logic signed [KEY_W-1:0] recent_keys [$];

	bdqks_req_if req ();
	bdqks_rsp_if rsp ();

	bounded_deque_with_key_search DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	deque_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.pending (pending),
		.errors  (errors)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", stalled_cycles);
			$display("tb_bounded_deque_with_key_search: errors");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// offer one request, with random gaps outside the quiet stretch
	task automatic offer_request(input req_t op, input logic signed [KEY_W-1:0] k);
		if (offered < QUIET_FIRST || offered > QUIET_LAST) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				req.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req.valid    <= 1'b1;
		req.req_type <= op;
		req.key      <= k;
		do @(posedge clk); while (!req.ready);
		offered++;
		if (op == REQ_PUSH) begin
			recent_keys.push_back(k);
			if (recent_keys.size() > RECENT_KEYS)
				void'(recent_keys.pop_front());
		end
	endtask

	// favour keys already pushed and a small range, so searches hit
	function automatic logic signed [KEY_W-1:0] choose_key();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40 && recent_keys.size() != 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		if (roll < 65)
			return $signed($urandom_range(0, 15)) - 8;
		if (roll < 75) begin
			case ($urandom_range(0, 3))
				0:       return KEY_MIN;
				1:       return KEY_MAX;
				2:       return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic req_t pick_request(input traffic_bias_t bias);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (bias)
			BIAS_GROW:
				return roll < 65 ? REQ_PUSH : roll < 75 ? REQ_POP_HEAD :
					roll < 82 ? REQ_POP_TAIL : REQ_SEARCH;
			BIAS_SHRINK:
				return roll < 15 ? REQ_PUSH : roll < 45 ? REQ_POP_HEAD :
					roll < 75 ? REQ_POP_TAIL : REQ_SEARCH;
			default:
				return roll < 35 ? REQ_PUSH : roll < 50 ? REQ_POP_HEAD :
					roll < 65 ? REQ_POP_TAIL : REQ_SEARCH;
		endcase
	endfunction

	// response side: random stalls, a quiet stretch and long hold-offs
	initial begin : response_side
		int unsigned taken;
		int unsigned hold_left;
		taken     = 0;
		hold_left = 0;
		rsp.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (taken >= QUIET_FIRST && taken <= QUIET_LAST) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				taken++;
				if (taken % 700 == 100)
					hold_left = HOLD_CYCLES;
			end
		end
	end

	// request side and verdict
	initial begin : request_side
		traffic_bias_t bias;
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.req_type <= REQ_PUSH;
		req.key      <= '0;
		bias = BIAS_MIXED;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: both pops and a search
		offer_request(REQ_POP_HEAD, KEY_MAX);
		offer_request(REQ_POP_TAIL, KEY_MIN);
		offer_request(REQ_SEARCH, '0);
		// extremes, with a duplicate of the largest key
		offer_request(REQ_PUSH, KEY_MIN);
		offer_request(REQ_PUSH, KEY_MAX);
		offer_request(REQ_PUSH, '0);
		offer_request(REQ_PUSH, '1);
		offer_request(REQ_PUSH, 1);
		offer_request(REQ_PUSH, KEY_MAX);
		// first match, match next to the tail, head match, absent key, inner match
		offer_request(REQ_SEARCH, KEY_MAX);
		offer_request(REQ_SEARCH, 1);
		offer_request(REQ_SEARCH, KEY_MIN);
		offer_request(REQ_SEARCH, 12345);
		offer_request(REQ_SEARCH, '1);
		// drain from both ends, re-searching after the head moves
		offer_request(REQ_POP_HEAD, '0);
		offer_request(REQ_POP_TAIL, '0);
		offer_request(REQ_SEARCH, KEY_MAX);
		offer_request(REQ_POP_HEAD, '1);
		offer_request(REQ_POP_TAIL, '1);
		offer_request(REQ_POP_HEAD, KEY_MIN);
		offer_request(REQ_POP_HEAD, KEY_MAX);
		offer_request(REQ_POP_TAIL, '0);

		// random traffic in blocks, leaning towards growth to reach full
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BLOCK_ITEMS == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: bias = BIAS_GROW;
					4, 5, 6:    bias = BIAS_SHRINK;
					default:    bias = BIAS_MIXED;
				endcase
			end
			offer_request(pick_request(bias), choose_key());
		end
		req.valid <= 1'b0;

		// wait for the last results, then for any stray ones
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_bounded_deque_with_key_search: clean");
		else
			$display("tb_bounded_deque_with_key_search: errors");
		$finish;
	end

endmodule
